// File: rtl/core/qwsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qwsc_pkg;

   localparam int CNT_W      = 12;   // row/column counts and image sizes
   localparam int FRAC_W     = 8;    // fractional bits of a position
   localparam int OUT_W      = 20;   // result position width
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int Y_LSB      = 16;   // y half of a packed corner

   localparam logic [CNT_W-1:0] OUT_ROWS_RST   = 12'd100;
   localparam logic [CNT_W-1:0] OUT_COLS_RST   = 12'd200;
   localparam logic [CNT_W-1:0] IMAGE_COLS_RST = 12'd640;
   localparam logic [CNT_W-1:0] IMAGE_ROWS_RST = 12'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UPPER_LEFT  = 3'd0,
      CSR_UPPER_RIGHT = 3'd1,
      CSR_LOWER_LEFT  = 3'd2,
      CSR_LOWER_RIGHT = 3'd3,
      CSR_OUT_ROWS    = 3'd4,
      CSR_OUT_COLS    = 3'd5,
      CSR_IMAGE_COLS  = 3'd6,
      CSR_IMAGE_ROWS  = 3'd7
   } csr_index_type;

   // interpolations run by the shared multiply/divide unit, in order
   typedef enum logic [2:0] {
      OP_LEFT_X  = 3'd0,
      OP_LEFT_Y  = 3'd1,
      OP_RIGHT_X = 3'd2,
      OP_RIGHT_Y = 3'd3,
      OP_POS_X   = 3'd4,
      OP_POS_Y   = 3'd5
   } op_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIFF = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIX  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/core/quad_warp_sample_coordinates_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sampling grid generator for a quadrilateral-to-rectangle warp. Each accepted
// request beat yields one response beat: the source position (8 fractional
// bits) of the next output pixel in row-major order, a fill flag for
// positions outside the source image interior and a last-sample flag.
// Corners, output size and image size are written over the csr port; the
// user must write them only while the block is idle, which the block itself
// does not enforce. All interpolations go through one multiplier and one
// radix-4 restoring divider under a small sequencer. A pixel runs its x and
// y interpolations; the first pixel of a row first runs those of both edges.
// The next request is taken while a response still waits.
module quad_warp_sample_coordinates_top #(
   parameter int COORD_BITS = 12
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_restart,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [qwsc_pkg::OUT_W-1:0]            rsp_source_x,
   output logic [qwsc_pkg::OUT_W-1:0]            rsp_source_y,
   output logic                                  rsp_use_fill,
   output logic                                  rsp_last_sample,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [qwsc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [qwsc_pkg::CSR_DATA_W-1:0]       csr_data
);
   import qwsc_pkg::*;

   localparam int POS_W     = COORD_BITS + FRAC_W;        // fixed-point position
   localparam int DIFF_W    = POS_W + 1;                  // signed difference
   localparam int PROD_W    = DIFF_W + CNT_W + 1;
   localparam int MAG_W     = POS_W + CNT_W;              // |pos * diff|
   localparam int DIV_W     = MAG_W + (MAG_W % 2);
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int ITER_W    = $clog2(DIV_STEPS);
   localparam int CMP_W     = (COORD_BITS > CNT_W ? COORD_BITS : CNT_W) + 1;

   // configuration
   logic [COORD_BITS-1:0] ulx_ff, uly_ff, urx_ff, ury_ff;
   logic [COORD_BITS-1:0] llx_ff, lly_ff, lrx_ff, lry_ff;
   logic [CNT_W-1:0]      out_rows_ff, out_cols_ff, image_cols_ff, image_rows_ff;

   // sequencer and datapath
   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [CNT_W-1:0]      row_ff, row_in, col_ff, col_in;
   logic [POS_W-1:0]      lex_ff, lex_in, ley_ff, ley_in;
   logic [POS_W-1:0]      rex_ff, rex_in, rey_ff, rey_in;
   logic [POS_W-1:0]      px_ff, px_in, py_ff, py_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [POS_W-1:0]      start_ff, start_in;
   logic [CNT_W-1:0]      pos_ff, pos_in, dvs_ff, dvs_in;
   logic                  neg_ff, neg_in;
   logic [DIV_W-1:0]      dq_ff, dq_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                  rsp_fill_ff, rsp_fill_in, rsp_last_ff, rsp_last_in;

   // helpers
   logic [CNT_W-1:0]      rows_eff, cols_eff;
   logic [CNT_W:0]        r_tmp, c_tmp;
   logic [CNT_W-1:0]      r_adj, c_adj;
   logic [POS_W-1:0]      sel_start, sel_end;
   logic signed [PROD_W-1:0] prod;
   logic [PROD_W-1:0]     prod_mag;
   logic [CNT_W:0]        t1, t2;
   logic                  ge1, ge2;
   logic [CNT_W-1:0]      r1;
   logic [DIFF_W-1:0]     q_mag, q_sgn, fix_res;
   logic [POS_W-1:0]      fix_pos;
   logic [CMP_W-1:0]      ix1, iy1;
   logic                  fill, last;
   logic                  out_free;
   logic [POS_W+OUT_W-1:0] x_ext, y_ext;

   assign csr_ready       = 1'b1;
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_source_x    = rsp_x_ff;
   assign rsp_source_y    = rsp_y_ff;
   assign rsp_use_fill    = rsp_fill_ff;
   assign rsp_last_sample = rsp_last_ff;

   assign rows_eff = (out_rows_ff == '0) ? CNT_W'(1) : out_rows_ff;
   assign cols_eff = (out_cols_ff == '0) ? CNT_W'(1) : out_cols_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ulx_ff <= '0; uly_ff <= '0; urx_ff <= '0; ury_ff <= '0;
         llx_ff <= '0; lly_ff <= '0; lrx_ff <= '0; lry_ff <= '0;
         out_rows_ff   <= OUT_ROWS_RST;
         out_cols_ff   <= OUT_COLS_RST;
         image_cols_ff <= IMAGE_COLS_RST;
         image_rows_ff <= IMAGE_ROWS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_UPPER_LEFT: begin
               ulx_ff <= csr_data[COORD_BITS-1:0];
               uly_ff <= csr_data[Y_LSB +: COORD_BITS];
            end
            CSR_UPPER_RIGHT: begin
               urx_ff <= csr_data[COORD_BITS-1:0];
               ury_ff <= csr_data[Y_LSB +: COORD_BITS];
            end
            CSR_LOWER_LEFT: begin
               llx_ff <= csr_data[COORD_BITS-1:0];
               lly_ff <= csr_data[Y_LSB +: COORD_BITS];
            end
            CSR_LOWER_RIGHT: begin
               lrx_ff <= csr_data[COORD_BITS-1:0];
               lry_ff <= csr_data[Y_LSB +: COORD_BITS];
            end
            CSR_OUT_ROWS:   out_rows_ff   <= csr_data[CNT_W-1:0];
            CSR_OUT_COLS:   out_cols_ff   <= csr_data[CNT_W-1:0];
            CSR_IMAGE_COLS: image_cols_ff <= csr_data[CNT_W-1:0];
            CSR_IMAGE_ROWS: image_rows_ff <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // operand selection for the current interpolation
   always_comb begin
      case (op_ff)
         OP_LEFT_X: begin
            sel_start = {ulx_ff, {FRAC_W{1'b0}}};
            sel_end   = {llx_ff, {FRAC_W{1'b0}}};
         end
         OP_LEFT_Y: begin
            sel_start = {uly_ff, {FRAC_W{1'b0}}};
            sel_end   = {lly_ff, {FRAC_W{1'b0}}};
         end
         OP_RIGHT_X: begin
            sel_start = {urx_ff, {FRAC_W{1'b0}}};
            sel_end   = {lrx_ff, {FRAC_W{1'b0}}};
         end
         OP_RIGHT_Y: begin
            sel_start = {ury_ff, {FRAC_W{1'b0}}};
            sel_end   = {lry_ff, {FRAC_W{1'b0}}};
         end
         OP_POS_X: begin
            sel_start = lex_ff;
            sel_end   = rex_ff;
         end
         default: begin
            sel_start = ley_ff;
            sel_end   = rey_ff;
         end
      endcase
   end

   assign prod     = $signed({1'b0, pos_ff}) * diff_ff;
   assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

   // two restoring divide steps per cycle
   assign t1  = {rem_ff, dq_ff[DIV_W-1]};
   assign ge1 = (t1 >= {1'b0, dvs_ff});
   assign r1  = ge1 ? CNT_W'(t1 - {1'b0, dvs_ff}) : t1[CNT_W-1:0];
   assign t2  = {r1, dq_ff[DIV_W-2]};
   assign ge2 = (t2 >= {1'b0, dvs_ff});

   assign q_mag   = {1'b0, dq_ff[POS_W-1:0]};
   assign q_sgn   = neg_ff ? DIFF_W'(-q_mag) : q_mag;
   assign fix_res = {1'b0, start_ff} + q_sgn;
   assign fix_pos = fix_res[POS_W-1:0];

   // status of the finished pixel
   assign ix1   = CMP_W'(px_ff[POS_W-1:FRAC_W]) + CMP_W'(1);
   assign iy1   = CMP_W'(py_ff[POS_W-1:FRAC_W]) + CMP_W'(1);
   assign fill  = !((ix1 < CMP_W'(image_cols_ff)) && (iy1 < CMP_W'(image_rows_ff)));
   assign last  = ({1'b0, row_ff} + (CNT_W+1)'(1) == {1'b0, rows_eff}) &&
                  ({1'b0, col_ff} + (CNT_W+1)'(1) == {1'b0, cols_eff});
   assign x_ext = {{OUT_W{1'b0}}, px_ff};
   assign y_ext = {{OUT_W{1'b0}}, py_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      lex_in   = lex_ff;
      ley_in   = ley_ff;
      rex_in   = rex_ff;
      rey_in   = rey_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      diff_in  = diff_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      iter_in  = iter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_fill_in = rsp_fill_ff;
      rsp_last_in = rsp_last_ff;
      r_tmp = '0;
      c_tmp = '0;
      r_adj = '0;
      c_adj = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // restart, then wrap for sizes shrunk mid-image
               r_tmp = {1'b0, req_restart ? CNT_W'(0) : row_ff};
               c_adj = req_restart ? '0 : col_ff;
               if ({1'b0, c_adj} >= {1'b0, cols_eff}) begin
                  c_adj = '0;
                  r_tmp = r_tmp + (CNT_W+1)'(1);
               end
               r_adj  = (r_tmp >= {1'b0, rows_eff}) ? '0 : r_tmp[CNT_W-1:0];
               row_in = r_adj;
               col_in = c_adj;
               op_in  = (c_adj == '0) ? OP_LEFT_X : OP_POS_X;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = $signed({1'b0, sel_end}) - $signed({1'b0, sel_start});
            start_in = sel_start;
            if (op_ff == OP_POS_X || op_ff == OP_POS_Y) begin
               pos_in = col_ff;
               dvs_in = cols_eff;
            end else begin
               pos_in = row_ff;
               dvs_in = rows_eff;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            neg_in   = prod[PROD_W-1];
            dq_in    = DIV_W'(prod_mag[MAG_W-1:0]);
            rem_in   = '0;
            iter_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = ge2 ? CNT_W'(t2 - {1'b0, dvs_ff}) : t2[CNT_W-1:0];
            dq_in   = {dq_ff[DIV_W-3:0], ge1, ge2};
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(DIV_STEPS - 1))
               state_in = ST_FIX;
         end
         ST_FIX: begin
            state_in = ST_DIFF;
            case (op_ff)
               OP_LEFT_X: begin
                  lex_in = fix_pos;
                  op_in  = OP_LEFT_Y;
               end
               OP_LEFT_Y: begin
                  ley_in = fix_pos;
                  op_in  = OP_RIGHT_X;
               end
               OP_RIGHT_X: begin
                  rex_in = fix_pos;
                  op_in  = OP_RIGHT_Y;
               end
               OP_RIGHT_Y: begin
                  rey_in = fix_pos;
                  op_in  = OP_POS_X;
               end
               OP_POS_X: begin
                  px_in = fix_pos;
                  op_in = OP_POS_Y;
               end
               default: begin
                  py_in    = fix_pos;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_ext[OUT_W-1:0];
               rsp_y_in     = y_ext[OUT_W-1:0];
               rsp_fill_in  = fill;
               rsp_last_in  = last;
               c_tmp = {1'b0, col_ff} + (CNT_W+1)'(1);
               r_tmp = {1'b0, row_ff} + (CNT_W+1)'(1);
               if (c_tmp >= {1'b0, cols_eff}) begin
                  col_in = '0;
                  row_in = (r_tmp >= {1'b0, rows_eff}) ? '0 : r_tmp[CNT_W-1:0];
               end else begin
                  col_in = c_tmp[CNT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_LEFT_X;
         row_ff       <= '0;
         col_ff       <= '0;
         lex_ff       <= '0;
         ley_ff       <= '0;
         rex_ff       <= '0;
         rey_ff       <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         lex_ff       <= lex_in;
         ley_ff       <= ley_in;
         rex_ff       <= rex_in;
         rey_ff       <= rey_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      diff_ff     <= diff_in;
      start_ff    <= start_in;
      pos_ff      <= pos_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_fill_ff <= rsp_fill_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

// File: verif/quad_warp_sample_coordinates_top_test.sv
`timescale 1ns / 1ps

import qwsc_pkg::*;

localparam int GRID_COORD_BITS = 12;

typedef struct packed {
   logic [OUT_W-1:0] source_x;
   logic [OUT_W-1:0] source_y;
   logic             use_fill;
   logic             last_sample;
} grid_sample_type;

// Tracks corners, sizes and the row/column walk; queues the positions that
// the block must produce, oldest first.
class grid_position_board;
   logic [CSR_DATA_W-1:0]        upper_left, upper_right, lower_left, lower_right;
   logic [CNT_W-1:0]             out_rows, out_cols, image_cols, image_rows;
   logic [CNT_W-1:0]             row_count, col_count;
   longint                       left_x, left_y, right_x, right_y;
   grid_sample_type              expected_samples[$];
   int                           errors;

   function new();
      upper_left  = '0;
      upper_right = '0;
      lower_left  = '0;
      lower_right = '0;
      out_rows    = OUT_ROWS_RST;
      out_cols    = OUT_COLS_RST;
      image_cols  = IMAGE_COLS_RST;
      image_rows  = IMAGE_ROWS_RST;
      row_count   = '0;
      col_count   = '0;
      left_x      = 0;
      left_y      = 0;
      right_x     = 0;
      right_y     = 0;
      errors      = 0;
   endfunction

   function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_UPPER_LEFT:  upper_left  = value;
         CSR_UPPER_RIGHT: upper_right = value;
         CSR_LOWER_LEFT:  lower_left  = value;
         CSR_LOWER_RIGHT: lower_right = value;
         CSR_OUT_ROWS:    out_rows    = value[CNT_W-1:0];
         CSR_OUT_COLS:    out_cols    = value[CNT_W-1:0];
         CSR_IMAGE_COLS:  image_cols  = value[CNT_W-1:0];
         CSR_IMAGE_ROWS:  image_rows  = value[CNT_W-1:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_samples.size();
   endfunction

   function longint coord(logic [CSR_DATA_W-1:0] corner, int shift);
      return longint'((corner >> shift) & ((32'd1 << GRID_COORD_BITS) - 1));
   endfunction

   // whole-pixel endpoints, result carries FRAC_W fraction bits
   function longint edge_point(longint start, longint stop, longint pos, longint count);
      return (pos * (stop - start) * (longint'(1) << FRAC_W)) / count
             + start * (longint'(1) << FRAC_W);
   endfunction

   function longint row_point(longint start, longint stop, longint pos, longint count);
      return (pos * (stop - start)) / count + start;
   endfunction

   function void note_request(logic restart);
      logic [CNT_W-1:0] rows, cols;
      longint           xp, yp;
      longint           row_pos, row_cnt, col_pos, col_cnt;
      grid_sample_type  sample;
      rows = (out_rows == '0) ? CNT_W'(1) : out_rows;
      cols = (out_cols == '0) ? CNT_W'(1) : out_cols;
      if (restart) begin
         row_count = '0;
         col_count = '0;
      end
      // sizes may have shrunk under the walk
      if (col_count >= cols) begin
         col_count = '0;
         row_count++;
      end
      if (row_count >= rows)
         row_count = '0;
      row_pos = longint'(row_count);
      row_cnt = longint'(rows);
      col_pos = longint'(col_count);
      col_cnt = longint'(cols);
      if (col_count == '0) begin
         left_x  = edge_point(coord(upper_left, 0), coord(lower_left, 0), row_pos, row_cnt);
         left_y  = edge_point(coord(upper_left, Y_LSB), coord(lower_left, Y_LSB),
                              row_pos, row_cnt);
         right_x = edge_point(coord(upper_right, 0), coord(lower_right, 0), row_pos,
                              row_cnt);
         right_y = edge_point(coord(upper_right, Y_LSB), coord(lower_right, Y_LSB),
                              row_pos, row_cnt);
      end
      xp = row_point(left_x, right_x, col_pos, col_cnt);
      yp = row_point(left_y, right_y, col_pos, col_cnt);
      sample.source_x    = xp[OUT_W-1:0];
      sample.source_y    = yp[OUT_W-1:0];
      sample.use_fill    = !(xp >= 0 && yp >= 0 &&
                             (xp >>> FRAC_W) < longint'(image_cols) - 1 &&
                             (yp >>> FRAC_W) < longint'(image_rows) - 1);
      sample.last_sample = (row_count == rows - 1'b1) && (col_count == cols - 1'b1);
      expected_samples.push_back(sample);
      col_count++;
      if (col_count >= cols) begin
         col_count = '0;
         row_count++;
         if (row_count >= rows)
            row_count = '0;
      end
   endfunction

   function void check_position(grid_sample_type got);
      grid_sample_type want;
      if (expected_samples.size() == 0) begin
         $error("response beat with no request pending: x %0h y %0h", got.source_x,
                got.source_y);
         errors++;
         return;
      end
      want = expected_samples.pop_front();
      if (got.source_x !== want.source_x) begin
         $error("source_x: expected %0h, got %0h", want.source_x, got.source_x);
         errors++;
      end
      if (got.source_y !== want.source_y) begin
         $error("source_y: expected %0h, got %0h", want.source_y, got.source_y);
         errors++;
      end
      if (got.use_fill !== want.use_fill) begin
         $error("use_fill: expected %0b, got %0b", want.use_fill, got.use_fill);
         errors++;
      end
      if (got.last_sample !== want.last_sample) begin
         $error("last_sample: expected %0b, got %0b", want.last_sample, got.last_sample);
         errors++;
      end
   endfunction
endclass

module quad_warp_sample_coordinates_top_test;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int SETTLE_CYCLES = 120;
   localparam int RANDOM_PHASES = 40;
   localparam int PHASE_ITEMS   = 38;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_restart = 1'b0;
   logic                  rsp_stall   = 1'b0;
   logic                  csr_valid   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_data    = '0;
   wire                   req_stall;
   wire                   rsp_valid;
   wire  [OUT_W-1:0]      rsp_source_x;
   wire  [OUT_W-1:0]      rsp_source_y;
   wire                   rsp_use_fill;
   wire                   rsp_last_sample;
   wire                   csr_ready;

   idle_mode_type      idle_mode = IDLE_NONE;
   grid_position_board grid      = new();

   quad_warp_sample_coordinates_top #(
      .COORD_BITS(GRID_COORD_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_source_x    (rsp_source_x),
      .rsp_source_y    (rsp_source_y),
      .rsp_use_fill    (rsp_use_fill),
      .rsp_last_sample (rsp_last_sample),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic bit side_idles(idle_mode_type busy_mode);
      if (idle_mode == busy_mode)
         return $urandom_range(0, 99) < 76;
      if (idle_mode == IDLE_BOTH)
         return $urandom_range(0, 99) < 16;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         grid.check_position({rsp_source_x, rsp_source_y, rsp_use_fill, rsp_last_sample});
      rsp_stall <= side_idles(IDLE_RECEIVER);
   end

   task automatic send_requests(input int count, input int restart_pct);
      int issued;
      issued = 0;
      forever begin
         @(posedge clock);
         if (req_valid && !req_stall)
            grid.note_request(req_restart);
         if (!req_valid || !req_stall) begin
            if (issued < count && !side_idles(IDLE_SENDER)) begin
               req_valid   <= 1'b1;
               req_restart <= ($urandom_range(0, 99) < restart_pct);
               issued++;
            end else begin
               req_valid <= 1'b0;
               if (issued == count)
                  break;
            end
         end
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      grid.write_reg(idx, value);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (grid.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_corner();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // mostly tiny output images so that whole images and wraps fit in a phase
   function automatic logic [CSR_DATA_W-1:0] pick_out_size();
      case ($urandom_range(0, 19))
         0:       return 32'(0);
         1:       return 32'(4095);
         2:       return {20'($urandom_range(0, 1048575)), 12'(0)} |
                         32'($urandom_range(1, 6));
         default: return 32'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_image_size();
      case ($urandom_range(0, 9))
         0:       return 32'($urandom_range(0, 1));
         1:       return 32'(4095);
         2:       return 32'(2);
         default: return ($urandom & 32'hFFFF_F000) | 32'($urandom_range(2, 4095));
      endcase
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // corners at the extremes; y bits above the coordinate width are ignored
      write_csr(CSR_UPPER_LEFT,  32'h0000_0000);
      write_csr(CSR_UPPER_RIGHT, 32'hF000_FFFF);
      write_csr(CSR_LOWER_LEFT,  32'hFFFF_0000);
      write_csr(CSR_LOWER_RIGHT, 32'hFFFF_FFFF);
      write_csr(CSR_OUT_ROWS,    32'd2);
      write_csr(CSR_OUT_COLS,    32'd3);
      write_csr(CSR_IMAGE_COLS,  32'd4095);
      write_csr(CSR_IMAGE_ROWS,  32'd4095);
      send_requests(7, 0);        // whole image, then wrap into the next
      send_requests(1, 100);
      drain();

      // zero output size with a degenerate source image
      write_csr(CSR_OUT_ROWS,   32'd0);
      write_csr(CSR_OUT_COLS,   32'd0);
      write_csr(CSR_IMAGE_COLS, 32'd1);
      write_csr(CSR_IMAGE_ROWS, 32'd0);
      send_requests(3, 0);
      drain();

      write_csr(CSR_OUT_ROWS,   32'd4095);
      write_csr(CSR_OUT_COLS,   32'd5);
      write_csr(CSR_IMAGE_COLS, 32'd2);
      write_csr(CSR_IMAGE_ROWS, 32'd2);
      send_requests(1, 100);
      send_requests(3, 0);
      drain();

      // columns shrink under the walk; corner moves mid-row
      write_csr(CSR_UPPER_LEFT, 32'h0123_0456);
      write_csr(CSR_OUT_COLS,   32'd2);
      send_requests(3, 0);
      drain();

      write_csr(CSR_OUT_COLS, 32'd4095);
      send_requests(1, 100);
      send_requests(2, 0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         idle_mode = idle_mode_type'(phase % 4);
         if (phase == 0 || $urandom_range(0, 1))
            write_csr(CSR_UPPER_LEFT, pick_corner());
         if (phase == 0 || $urandom_range(0, 1))
            write_csr(CSR_UPPER_RIGHT, pick_corner());
         if (phase == 0 || $urandom_range(0, 1))
            write_csr(CSR_LOWER_LEFT, pick_corner());
         if (phase == 0 || $urandom_range(0, 1))
            write_csr(CSR_LOWER_RIGHT, pick_corner());
         if (phase == 0 || $urandom_range(0, 1))
            write_csr(CSR_OUT_ROWS, pick_out_size());
         if (phase == 0 || $urandom_range(0, 1))
            write_csr(CSR_OUT_COLS, pick_out_size());
         if (phase == 0 || $urandom_range(0, 1))
            write_csr(CSR_IMAGE_COLS, pick_image_size());
         if (phase == 0 || $urandom_range(0, 1))
            write_csr(CSR_IMAGE_ROWS, pick_image_size());
         send_requests(PHASE_ITEMS, 3);
      end

      drain();
      if (grid.errors == 0 && grid.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: quad_warp_sample_coordinates_top.f
rtl/core/qwsc_pkg.sv
rtl/core/quad_warp_sample_coordinates_top.sv
verif/quad_warp_sample_coordinates_top_test.sv
